// ===== sv/rtp_pkg.sv =====
// Package for the ringtone text note parser: types, codes and the key ROM.
// No dependencies.
package rtp_pkg;

  localparam logic [1:0] KIND_TONE  = 2'd0;
  localparam logic [1:0] KIND_REST  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] SEC_NAME   = 2'd0;
  localparam logic [1:0] SEC_HEADER = 2'd1;
  localparam logic [1:0] SEC_NOTES  = 2'd2;
  localparam logic [1:0] SEC_CTL    = 2'd3;

  localparam int KEY_MIN  = -8;
  localparam int ROM_SIZE = 121;

  // Key ROM, indexed by key + 8.
  function automatic logic [14:0] key_freq(input logic [6:0] idx);
    logic [14:0] f;
    case (idx)
      7'd0: f = 15'd16;     7'd1: f = 15'd17;     7'd2: f = 15'd18;     7'd3: f = 15'd19;
      7'd4: f = 15'd21;     7'd5: f = 15'd22;     7'd6: f = 15'd23;     7'd7: f = 15'd24;
      7'd8: f = 15'd26;     7'd9: f = 15'd28;     7'd10: f = 15'd29;    7'd11: f = 15'd31;
      7'd12: f = 15'd33;    7'd13: f = 15'd35;    7'd14: f = 15'd37;    7'd15: f = 15'd39;
      7'd16: f = 15'd41;    7'd17: f = 15'd44;    7'd18: f = 15'd46;    7'd19: f = 15'd49;
      7'd20: f = 15'd52;    7'd21: f = 15'd55;    7'd22: f = 15'd58;    7'd23: f = 15'd62;
      7'd24: f = 15'd65;    7'd25: f = 15'd69;    7'd26: f = 15'd73;    7'd27: f = 15'd78;
      7'd28: f = 15'd82;    7'd29: f = 15'd87;    7'd30: f = 15'd92;    7'd31: f = 15'd98;
      7'd32: f = 15'd104;   7'd33: f = 15'd110;   7'd34: f = 15'd117;   7'd35: f = 15'd123;
      7'd36: f = 15'd131;   7'd37: f = 15'd139;   7'd38: f = 15'd147;   7'd39: f = 15'd156;
      7'd40: f = 15'd165;   7'd41: f = 15'd175;   7'd42: f = 15'd185;   7'd43: f = 15'd196;
      7'd44: f = 15'd208;   7'd45: f = 15'd220;   7'd46: f = 15'd233;   7'd47: f = 15'd247;
      7'd48: f = 15'd262;   7'd49: f = 15'd277;   7'd50: f = 15'd294;   7'd51: f = 15'd311;
      7'd52: f = 15'd330;   7'd53: f = 15'd349;   7'd54: f = 15'd370;   7'd55: f = 15'd392;
      7'd56: f = 15'd415;   7'd57: f = 15'd440;   7'd58: f = 15'd466;   7'd59: f = 15'd494;
      7'd60: f = 15'd523;   7'd61: f = 15'd554;   7'd62: f = 15'd587;   7'd63: f = 15'd622;
      7'd64: f = 15'd659;   7'd65: f = 15'd698;   7'd66: f = 15'd740;   7'd67: f = 15'd784;
      7'd68: f = 15'd831;   7'd69: f = 15'd880;   7'd70: f = 15'd932;   7'd71: f = 15'd988;
      7'd72: f = 15'd1047;  7'd73: f = 15'd1109;  7'd74: f = 15'd1175;  7'd75: f = 15'd1245;
      7'd76: f = 15'd1319;  7'd77: f = 15'd1397;  7'd78: f = 15'd1480;  7'd79: f = 15'd1568;
      7'd80: f = 15'd1661;  7'd81: f = 15'd1760;  7'd82: f = 15'd1865;  7'd83: f = 15'd1976;
      7'd84: f = 15'd2093;  7'd85: f = 15'd2217;  7'd86: f = 15'd2349;  7'd87: f = 15'd2489;
      7'd88: f = 15'd2637;  7'd89: f = 15'd2794;  7'd90: f = 15'd2960;  7'd91: f = 15'd3136;
      7'd92: f = 15'd3322;  7'd93: f = 15'd3520;  7'd94: f = 15'd3729;  7'd95: f = 15'd3951;
      7'd96: f = 15'd4186;  7'd97: f = 15'd4435;  7'd98: f = 15'd4699;  7'd99: f = 15'd4978;
      7'd100: f = 15'd5274; 7'd101: f = 15'd5588; 7'd102: f = 15'd5920; 7'd103: f = 15'd6272;
      7'd104: f = 15'd6645; 7'd105: f = 15'd7040; 7'd106: f = 15'd7459; 7'd107: f = 15'd7902;
      7'd108: f = 15'd8372; 7'd109: f = 15'd8870; 7'd110: f = 15'd9397; 7'd111: f = 15'd9956;
      7'd112: f = 15'd10548; 7'd113: f = 15'd11175; 7'd114: f = 15'd11840;
      7'd115: f = 15'd12544; 7'd116: f = 15'd13290; 7'd117: f = 15'd14080;
      7'd118: f = 15'd14917; 7'd119: f = 15'd15804; 7'd120: f = 15'd16744;
      default: f = 15'd0;
    endcase
    return f;
  endfunction

  function automatic logic signed [4:0] letter_offset(input logic [2:0] i);
    logic signed [4:0] o;
    case (i)
      3'd0: o = 5'sd1;
      3'd1: o = 5'sd3;
      3'd2: o = -5'sd8;
      3'd3: o = -5'sd6;
      3'd4: o = -5'sd4;
      3'd5: o = -5'sd3;
      3'd6: o = -5'sd1;
      default: o = 5'sd3;
    endcase
    return o;
  endfunction

  // Request to the duration unit.
  typedef struct packed {
    logic        start;
    logic [15:0] tempo;
    logic [7:0]  len;
    logic [1:0]  dots;
  } dur_req_t;

  typedef struct packed {
    logic        done;
    logic [19:0] dur;
  } dur_rsp_t;

endpackage

// ===== sv/ringtone_text_note_parser.sv =====
// Top level of the ringtone text note parser: character parser and result control.
// Depends on rtp_pkg and rtp_dur_unit.
//
// One character is taken per transfer. After a character that gives no result,
// s_tready stays high for the next character. An error or end result goes
// straight to the output register. A character that completes a note runs the
// shared bit-serial divider (two 18-step divisions) and then the dot steps,
// and s_tready is low meanwhile. The result sits in an output register until
// m_tready takes it, and s_tready is low while it waits there.
module ringtone_text_note_parser #(
  parameter int MAX_OCTAVE = 9,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [14:0] frequency_hz, [34:15] duration_ms, [42:35] key_number
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // end_of_song
);
  import rtp_pkg::*;

  localparam logic [VALUE_BITS-1:0] ACC_MAX = {VALUE_BITS{1'b1}};
  localparam logic [3:0] MAXO = 4'(MAX_OCTAVE);

  typedef enum logic [2:0] {
    T_RUN  = 3'b001,
    T_WAIT = 3'b010,
    T_OUT  = 3'b100
  } tstate_t;

  tstate_t tstate;
  logic [1:0]  section;
  logic [2:0]  phase;
  logic [7:0]  ctl;
  logic [VALUE_BITS-1:0] acc;
  logic [7:0]  dlen;
  logic [3:0]  doct;
  logic [15:0] tempo;
  logic [7:0]  plen;
  logic [1:0]  dots;
  logic [7:0]  plet;
  logic        sharp;
  logic [3:0]  poct;
  logic [1:0]  tchars;
  logic        bad;

  // Held note for the duration wait
  logic [1:0]  w_kind;
  logic [14:0] w_freq;
  logic signed [7:0] w_key;
  logic        w_last;

  logic [1:0]  o_kind;
  logic [14:0] o_freq;
  logic [19:0] o_dur;
  logic [7:0]  o_key;
  logic        o_last;

  dur_req_t dreq;
  dur_rsp_t drsp;

  rtp_dur_unit u_dur (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // next-state of parser
  logic [1:0]  section_next;
  logic [2:0]  phase_next;
  logic [7:0]  ctl_next, dlen_next, plen_next, plet_next;
  logic [VALUE_BITS-1:0] acc_next;
  logic [3:0]  doct_next, poct_next;
  logic [15:0] tempo_next;
  logic [1:0]  dots_next, tchars_next;
  logic        sharp_next, bad_next;
  logic        emit;        // immediate result
  logic [1:0]  e_kind;
  logic        want_dur;    // note needs duration
  logic [14:0] n_freq;
  logic signed [7:0] n_key;
  logic [1:0]  n_kind;
  logic [7:0]  n_len;
  logic [1:0]  n_dots;
  logic [7:0]  c;
  logic        is_dig;

  always_comb begin
    logic [VALUE_BITS+3:0] v;
    logic [3:0] oct;
    logic signed [8:0] key;
    logic [7:0] up;
    logic fin_ctl, fin_note, last_fin;
    c  = s_tdata;
    is_dig = (c >= 8'h30) && (c <= 8'h39);
    v = {acc, 3'b0} + {2'b0, acc, 1'b0} + {{VALUE_BITS{1'b0}}, c[3:0]};
    up = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    section_next = section; phase_next = phase; ctl_next = ctl; acc_next = acc;
    dlen_next = dlen; doct_next = doct; tempo_next = tempo; plen_next = plen;
    dots_next = dots; plet_next = plet; sharp_next = sharp; poct_next = poct;
    tchars_next = tchars; bad_next = bad;
    emit = 1'b0; e_kind = KIND_END; want_dur = 1'b0;
    fin_ctl = 1'b0; fin_note = 1'b0; last_fin = 1'b0;
    n_len = 8'd0; n_kind = KIND_ERROR; n_freq = 15'd0; n_key = 8'sd0; n_dots = 2'd0;
    oct = 4'd0; key = 9'sd0;
    if (!(c == 8'd0 || c == 8'd32 || (c >= 8'd9 && c <= 8'd13))) begin
      unique case (section)
        SEC_NAME: if (c == 8'h3a) section_next = SEC_HEADER;
        SEC_HEADER, SEC_CTL: begin
          if (c == 8'h2c || (section == SEC_HEADER && c == 8'h3a)) begin
            fin_ctl = 1'b1;
            if (section == SEC_CTL || c == 8'h3a) section_next = SEC_NOTES;
          end else if (phase == 3'd0) begin
            ctl_next = c; phase_next = 3'd1;
          end else if (phase == 3'd1) begin
            if (c == 8'h3d) begin acc_next = '0; phase_next = 3'd2; end
            else begin bad_next = 1'b1; phase_next = 3'd3; end
          end else if (phase == 3'd2) begin
            if (is_dig) acc_next = (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[VALUE_BITS-1:0];
            else phase_next = 3'd3;
          end
        end
        default: begin
          if (c == 8'h2c) fin_note = 1'b1;
          else if (c == 8'h3d) begin
            if (tchars == 2'd0) begin ctl_next = 8'h3d; phase_next = 3'd1; end
            else if (tchars == 2'd1) begin acc_next = '0; bad_next = 1'b0; phase_next = 3'd2; end
            else begin bad_next = 1'b1; phase_next = 3'd3; end
            section_next = SEC_CTL;
          end else begin
            if (tchars == 2'd0) ctl_next = c;
            if (tchars != 2'd2) tchars_next = tchars + 2'd1;
            case (phase)
              3'd0, 3'd1: begin
                if (is_dig) begin
                  acc_next = (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[VALUE_BITS-1:0];
                  phase_next = 3'd1;
                end else begin
                  if (phase == 3'd1) begin
                    if (acc == '0) bad_next = 1'b1;
                    plen_next = (acc > VALUE_BITS'(255)) ? 8'd255 : 8'(acc);
                    acc_next = '0;
                  end
                  if (c == 8'h2e) begin
                    if (dots != 2'd3) dots_next = dots + 2'd1;
                    phase_next = 3'd2;
                  end else begin
                    plet_next = up; acc_next = '0; phase_next = 3'd3;
                  end
                end
              end
              3'd2: begin plet_next = up; acc_next = '0; phase_next = 3'd3; end
              3'd3, 3'd4, 3'd5, 3'd6: begin
                if (phase == 3'd3 && c == 8'h23) begin
                  sharp_next = 1'b1; phase_next = 3'd4;
                end else if (is_dig) begin
                  acc_next = (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[VALUE_BITS-1:0];
                  poct_next = ((acc_next > VALUE_BITS'(MAX_OCTAVE)) ? MAXO :
                               4'(acc_next)) + 4'd1;
                  phase_next = 3'd6;
                end else if (c == 8'h2e) begin
                  if (dots != 2'd3) dots_next = dots + 2'd1;
                  phase_next = (phase == 3'd3) ? 3'd5 : (phase == 3'd4) ? 3'd5 : 3'd7;
                end else phase_next = 3'd7;
              end
              default: ;
            endcase
          end
        end
      endcase
    end
    // end of text finishes the open token of the section reached after this character
    if (s_tlast && !fin_ctl && !fin_note) begin
      if (section_next == SEC_HEADER || section_next == SEC_CTL) begin
        fin_ctl = 1'b1; last_fin = 1'b1;
      end else if (section_next == SEC_NOTES) begin
        fin_note = 1'b1; last_fin = 1'b1;
      end
    end
    // finishing uses pre-character token state when the character was a separator;
    // for end of text without separator, it uses the state after this character
    if (fin_ctl) begin
      logic [2:0] ph; logic bd; logic [7:0] cl; logic [VALUE_BITS-1:0] av;
      ph = last_fin ? phase_next : phase; bd = last_fin ? bad_next : bad;
      cl = last_fin ? ctl_next : ctl;     av = last_fin ? acc_next : acc;
      if (ph != 3'd0) begin
        if (bd || ph == 3'd1) begin emit = 1'b1; e_kind = KIND_ERROR; end
        else if (cl == 8'h64) dlen_next = (av > VALUE_BITS'(255)) ? 8'd255 : 8'(av);
        else if (cl == 8'h6f) doct_next = (av > VALUE_BITS'(MAX_OCTAVE)) ? MAXO : 4'(av);
        else if (cl == 8'h62) tempo_next = 16'(av);
      end
    end
    if (fin_note) begin
      logic [2:0] ph; logic bd; logic [7:0] pl, lt; logic [3:0] po; logic sh;
      ph = last_fin ? phase_next : phase; bd = last_fin ? bad_next : bad;
      pl = last_fin ? plen_next : plen;   lt = last_fin ? plet_next : plet;
      po = last_fin ? poct_next : poct;   sh = last_fin ? sharp_next : sharp;
      n_dots = last_fin ? dots_next : dots;
      if (ph != 3'd0) begin
        n_len = (pl != 8'd0) ? pl : dlen;
        if (ph <= 3'd2 || bd || n_len == 8'd0 || tempo_next == 16'd0) begin
          emit = 1'b1; e_kind = KIND_ERROR;
        end else begin
          oct = (po != 4'd0) ? po - 4'd1 : doct;
          if (oct > MAXO) oct = MAXO;
          key = $signed({8'd0, sh}) + $signed({1'b0, 4'd0, oct} * 9'd12);
          if (lt >= 8'h41 && lt <= 8'h48) key = key + 9'(letter_offset(lt[2:0] - 3'd1));
          if (lt == 8'h50) begin
            n_kind = KIND_REST; want_dur = 1'b1;
          end else if (key >= -9'sd8 && key <= 9'sd112) begin
            n_kind = KIND_TONE; want_dur = 1'b1;
            n_freq = key_freq(7'(key + 9'sd8)); n_key = 8'(key);
          end else begin
            emit = 1'b1; e_kind = KIND_ERROR;
          end
        end
      end
    end
    if (fin_ctl || fin_note) begin
      phase_next = 3'd0; ctl_next = 8'd0; acc_next = '0; plen_next = 8'd0;
      dots_next = 2'd0; plet_next = 8'd0;
      sharp_next = 1'b0; poct_next = 4'd0; tchars_next = 2'd0; bad_next = 1'b0;
    end
    if (s_tlast && !emit && !want_dur) begin emit = 1'b1; e_kind = KIND_END; end
  end

  assign dreq.start = (tstate == T_RUN) && s_tvalid && want_dur;
  assign dreq.tempo = tempo_next;
  assign dreq.len   = n_len;
  assign dreq.dots  = n_dots;
  assign s_tready   = (tstate == T_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate <= T_RUN;
      section <= SEC_NAME; phase <= 3'd0; ctl <= 8'd0; acc <= '0;
      dlen <= 8'd4; doct <= (4'd6 > MAXO) ? MAXO : 4'd6; tempo <= 16'd63;
      plen <= 8'd0; dots <= 2'd0; plet <= 8'd0; sharp <= 1'b0; poct <= 4'd0;
      tchars <= 2'd0; bad <= 1'b0;
    end else begin
      unique case (tstate)
        T_RUN: begin
          if (s_tvalid) begin
            if (s_tlast) begin
              section <= SEC_NAME; phase <= 3'd0; ctl <= 8'd0; acc <= '0;
              dlen <= 8'd4; doct <= (4'd6 > MAXO) ? MAXO : 4'd6; tempo <= 16'd63;
              plen <= 8'd0; dots <= 2'd0; plet <= 8'd0; sharp <= 1'b0;
              poct <= 4'd0; tchars <= 2'd0; bad <= 1'b0;
            end else begin
              section <= section_next; phase <= phase_next; ctl <= ctl_next;
              acc <= acc_next; dlen <= dlen_next; doct <= doct_next; tempo <= tempo_next;
              plen <= plen_next; plet <= plet_next; sharp <= sharp_next;
              poct <= poct_next; tchars <= tchars_next; bad <= bad_next;
              dots <= dots_next;
            end
            w_kind <= n_kind; w_freq <= n_freq; w_key <= n_key; w_last <= s_tlast;
            if (want_dur) tstate <= T_WAIT;
            else if (emit) begin
              o_kind <= e_kind; o_freq <= 15'd0; o_dur <= 20'd0; o_key <= 8'd0;
              o_last <= s_tlast; tstate <= T_OUT;
            end
          end
        end
        T_WAIT: begin
          if (drsp.done) begin
            o_kind <= w_kind; o_freq <= w_freq; o_dur <= drsp.dur;
            o_key <= w_key; o_last <= w_last; tstate <= T_OUT;
          end
        end
        T_OUT: if (m_tready) tstate <= T_RUN;
        default: tstate <= T_RUN;
      endcase
    end
  end

  assign m_tvalid = (tstate == T_OUT);
  assign m_tdata  = {5'd0, o_key, o_dur, o_freq};
  assign m_tuser  = o_kind;
  assign m_tlast  = o_last;
endmodule

// ===== sv/rtp_dur_unit.sv =====
// Duration unit: restoring divider shared by both divisions, then the dot steps.
// Depends on rtp_pkg.
module rtp_dur_unit (
  input  logic              clk,
  input  logic              rst,
  input  rtp_pkg::dur_req_t req,
  output rtp_pkg::dur_rsp_t rsp
);
  import rtp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV1 = 5'b00010,
    S_DIV2 = 5'b00100,
    S_DOTS = 5'b01000,
    S_DONE = 5'b10000
  } dstate_t;

  dstate_t     state;
  logic [17:0] quot;
  logic [17:0] rem;
  logic [15:0] divisor;
  logic [4:0]  cnt;
  logic [7:0]  len;
  logic [1:0]  dots;
  logic [21:0] acc;

  logic [18:0] trial;
  logic [18:0] rem_sh;

  always_comb begin
    rem_sh = {rem, quot[17]};
    trial  = rem_sh - {3'd0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            quot    <= 18'd60000;
            rem     <= 18'd0;
            divisor <= req.tempo;
            len     <= req.len;
            dots    <= req.dots;
            cnt     <= 5'd17;
            state   <= S_DIV1;
          end
        end
        S_DIV1, S_DIV2: begin
          if (cnt != 5'd0) begin
            rem  <= trial[18] ? rem_sh[17:0] : trial[17:0];
            quot <= {quot[16:0], ~trial[18]};
            cnt  <= cnt - 5'd1;
          end else if (state == S_DIV1) begin
            // quotient times four, then divide by length
            quot    <= {quot[14:0], ~trial[18], 2'b00};
            rem     <= 18'd0;
            divisor <= {8'd0, len};
            cnt     <= 5'd17;
            state   <= S_DIV2;
          end else begin
            acc   <= {4'd0, quot[16:0], ~trial[18]};
            state <= S_DOTS;
          end
        end
        S_DOTS: begin
          if (dots == 2'd0) begin
            state <= S_DONE;
          end else begin
            acc  <= acc + {1'b0, acc[21:1]};
            dots <= dots - 2'd1;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = (state == S_DONE);
  assign rsp.dur  = acc[19:0];
endmodule

// ===== sv/rtp_checker.sv =====
// Port-level checks for the ringtone text note parser, bound to the top level.
// Depends on rtp_pkg and the ringtone_text_note_parser ports.
module rtp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import rtp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while result pending");
  a_err0: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_ERROR || m_tuser == KIND_END) |-> m_tdata == 48'd0)
    else $error("error or end result carries data");
  a_rest: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_REST |-> m_tdata[14:0] == 15'd0)
    else $error("rest with frequency");
endmodule

bind ringtone_text_note_parser rtp_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ===== tb/ringtone_text_note_parser_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the ringtone text note parser: watches both streams,
// predicts each result from the accepted characters and compares. Uses rtp_pkg.
module ringtone_text_note_parser_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending_notes
);
  import rtp_pkg::*;

  localparam int MAX_OCT = 9;
  localparam int ACC_MAX = 65535;

  typedef struct packed {
    logic [1:0]  kind;
    logic [14:0] freq;
    logic [19:0] dur;
    logic [7:0]  key;
    logic        eos;
  } note_t;

  note_t note_q[$];

  // parser state
  logic [1:0] sec;
  int phase, ctl_letter, acc, def_len, def_oct, tempo;
  int p_len, dots, p_letter, sharp, p_oct, tok_chars, tok_bad;

  function automatic int oct_rom(int key);
    int tab[121] = '{
      16, 17, 18, 19, 21, 22, 23, 24, 26, 28, 29, 31,
      33, 35, 37, 39, 41, 44, 46, 49, 52, 55, 58, 62,
      65, 69, 73, 78, 82, 87, 92, 98, 104, 110, 117, 123,
      131, 139, 147, 156, 165, 175, 185, 196, 208, 220, 233, 247,
      262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
      523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988,
      1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976,
      2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951,
      4186, 4435, 4699, 4978, 5274, 5588, 5920, 6272, 6645, 7040, 7459, 7902,
      8372, 8870, 9397, 9956, 10548, 11175, 11840, 12544, 13290, 14080, 14917,
      15804, 16744};
    return tab[key + 8];
  endfunction

  task automatic clear_tok();
    phase = 0; ctl_letter = 0; acc = 0; p_len = 0; dots = 0; p_letter = 0;
    sharp = 0; p_oct = 0; tok_chars = 0; tok_bad = 0;
  endtask

  task automatic song_reset();
    clear_tok();
    sec = SEC_NAME; def_len = 4; def_oct = 6; tempo = 63;
  endtask

  function automatic bit is_dig(int c);
    return c >= 48 && c <= 57;
  endfunction

  task automatic push_digit(int c);
    acc = acc * 10 + (c - 48);
    if (acc > ACC_MAX) acc = ACC_MAX;
  endtask

  task automatic add_dot();
    if (dots < 3) dots++;
  endtask

  task automatic ctl_char(int c);
    if (phase == 0) begin
      ctl_letter = c; phase = 1;
    end else if (phase == 1) begin
      if (c == "=") begin
        acc = 0; phase = 2;
      end else begin
        tok_bad = 1; phase = 3;
      end
    end else if (phase == 2) begin
      if (is_dig(c)) push_digit(c);
      else phase = 3;
    end
  endtask

  task automatic end_control(output bit got, output note_t r);
    got = 0; r = '0;
    if (phase != 0) begin
      if (tok_bad || phase == 1) begin
        got = 1; r.kind = KIND_ERROR;
      end else if (ctl_letter == "d") def_len = acc > 255 ? 255 : acc;
      else if (ctl_letter == "o") def_oct = acc > MAX_OCT ? MAX_OCT : acc;
      else if (ctl_letter == "b") tempo = acc;
    end
    clear_tok();
  endtask

  task automatic latch_len();
    if (acc == 0) tok_bad = 1;
    p_len = acc > 255 ? 255 : acc;
    acc = 0;
  endtask

  task automatic take_letter(int c);
    p_letter = (c >= 97 && c <= 122) ? c - 32 : c;
    acc = 0; phase = 3;
  endtask

  task automatic oct_digit(int c);
    push_digit(c);
    p_oct = (acc > MAX_OCT ? MAX_OCT : acc) + 1;
    phase = 6;
  endtask

  task automatic note_char(int c);
    case (phase)
      0: if (is_dig(c)) begin
        push_digit(c); phase = 1;
      end else if (c == ".") begin
        add_dot(); phase = 2;
      end else take_letter(c);
      1: if (is_dig(c)) push_digit(c);
      else if (c == ".") begin
        latch_len(); add_dot(); phase = 2;
      end else begin
        latch_len(); take_letter(c);
      end
      2: take_letter(c);
      3: if (c == "#") begin
        sharp = 1; phase = 4;
      end else if (c == ".") begin
        add_dot(); phase = 5;
      end else if (is_dig(c)) oct_digit(c);
      else phase = 7;
      4, 5: if (c == ".") begin
        add_dot(); phase = (phase == 4) ? 5 : 7;
      end else if (is_dig(c)) oct_digit(c);
      else phase = 7;
      6: if (is_dig(c)) oct_digit(c);
      else begin
        if (c == ".") add_dot();
        phase = 7;
      end
      default: ;
    endcase
  endtask

  task automatic end_note(output bit got, output note_t r);
    int len, oct, dur, key, offs[8];
    offs = '{1, 3, -8, -6, -4, -3, -1, 3};
    got = 0; r = '0;
    if (phase != 0) begin
      got = 1;
      len = p_len ? p_len : def_len;
      if (phase <= 2 || tok_bad || len == 0 || tempo == 0) r.kind = KIND_ERROR;
      else begin
        dur = ((60000 / tempo) * 4) / len;
        for (int i = 0; i < dots; i++) dur += dur / 2;
        oct = p_oct ? p_oct - 1 : def_oct;
        if (oct > MAX_OCT) oct = MAX_OCT;
        key = sharp + 12 * oct;
        if (p_letter >= 65 && p_letter <= 72) key += offs[p_letter - 65];
        if (p_letter == 80) begin
          r.kind = KIND_REST; r.dur = 20'(dur);
        end else if (key >= -8 && key <= 112) begin
          r.kind = KIND_TONE; r.freq = 15'(oct_rom(key)); r.dur = 20'(dur);
          r.key = 8'(key);
        end else r.kind = KIND_ERROR;
      end
    end
    clear_tok();
  endtask

  task automatic parse_char(int c, output bit got, output note_t r);
    got = 0; r = '0;
    case (sec)
      SEC_NAME: if (c == ":") begin
        sec = SEC_HEADER; clear_tok();
      end
      SEC_HEADER: if (c == "," || c == ":") begin
        end_control(got, r);
        if (c == ":") sec = SEC_NOTES;
      end else ctl_char(c);
      SEC_NOTES: if (c == ",") end_note(got, r);
      else if (c == "=") begin
        if (tok_chars == 0) begin
          ctl_letter = "="; phase = 1;
        end else if (tok_chars == 1) begin
          acc = 0; tok_bad = 0; phase = 2;
        end else begin
          tok_bad = 1; phase = 3;
        end
        sec = SEC_CTL;
      end else begin
        if (tok_chars == 0) ctl_letter = c;
        if (tok_chars < 2) tok_chars++;
        note_char(c);
      end
      default: if (c == ",") begin
        end_control(got, r); sec = SEC_NOTES;
      end else ctl_char(c);
    endcase
  endtask

  task automatic predict_char(int c, bit last);
    bit got;
    note_t r;
    got = 0; r = '0;
    if (!(c == 0 || c == 32 || (c >= 9 && c <= 13))) parse_char(c, got, r);
    if (last) begin
      if (!got) begin
        if (sec == SEC_HEADER || sec == SEC_CTL) end_control(got, r);
        else if (sec == SEC_NOTES) end_note(got, r);
      end
      if (!got) begin
        got = 1; r = '0; r.kind = KIND_END;
      end
      r.eos = 1;
      song_reset();
    end
    if (got) note_q.push_back(r);
  endtask

  task automatic report(string what, int got_v, int exp_v);
    fail_count++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got_v, exp_v, $realtime);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    note_t e;
    if (rst) begin
      song_reset();
      note_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (note_q.size() == 0) report("unexpected result kind", m_tuser, -1);
        else begin
          e = note_q.pop_front();
          if (m_tuser !== e.kind) report("kind", m_tuser, e.kind);
          if (m_tdata[14:0] !== e.freq) report("frequency_hz", m_tdata[14:0], e.freq);
          if (m_tdata[34:15] !== e.dur) report("duration_ms", m_tdata[34:15], e.dur);
          if (m_tdata[42:35] !== e.key)
            report("key_number", $signed(m_tdata[42:35]), $signed(e.key));
          if (m_tdata[47:43] !== 5'd0) report("tdata pad", m_tdata[47:43], 0);
          if (m_tlast !== e.eos) report("end_of_song", m_tlast, e.eos);
        end
      end
      if (s_tvalid && s_tready) predict_char(s_tdata, s_tlast);
    end
    pending_notes = note_q.size();
  end

endmodule

// ===== tb/tb_ringtone_text_note_parser.sv =====
`timescale 1ns / 1ps
// Testbench top for the ringtone text note parser: feeds song text, stalls
// the result side and gives the verdict. Needs rtp_pkg, the RTL and the checker.
module tb_ringtone_text_note_parser;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = 0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  int          fail_count, pending_notes;
  int          idle_pct = 16;
  int          quiet_cycles = 0;
  int          sent = 0;

  localparam int STALL_LIMIT = 2000;

  always #5 clk = ~clk;

  ringtone_text_note_parser DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  ringtone_text_note_parser_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .fail_count, .pending_notes
  );

  // receiver stalls at random
  always @(negedge clk) m_tready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("ringtone_text_note_parser verification failed");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_char(byte unsigned c, bit last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1; s_tdata <= c; s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_text(string s, bit close_song);
    for (int i = 0; i < s.len(); i++) send_char(s[i], close_song && i == s.len() - 1);
  endtask

  function automatic string rand_num(int maxd);
    string s = "";
    int n = $urandom_range(maxd, 1);
    for (int i = 0; i < n; i++) s = {s, string'(byte'(48 + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string rand_note();
    string s = "";
    string letters = "abcdefghpABCDEFGHPx";
    if ($urandom_range(1)) s = {s, rand_num(2)};
    if ($urandom_range(5) == 0) s = {s, "."};
    s = {s, string'(letters[$urandom_range(letters.len() - 1)])};
    if ($urandom_range(2) == 0) s = {s, "#"};
    if ($urandom_range(3) == 0) s = {s, "."};
    if ($urandom_range(1)) s = {s, rand_num(1)};
    if ($urandom_range(3) == 0) s = {s, "."};
    if ($urandom_range(9) == 0) s = {s, ".."};
    return s;
  endfunction

  function automatic string rand_ctl();
    string k = "dobq";
    string s = {string'(k[$urandom_range(3)]), "="};
    if ($urandom_range(9) == 0) s = {string'(k[$urandom_range(3)]), "x="};
    if ($urandom_range(7) != 0) s = {s, rand_num($urandom_range(1) ? 2 : 6)};
    return s;
  endfunction

  task automatic random_song();
    string s;
    s = $urandom_range(1) ? "tune " : "";
    s = {s, ":", rand_ctl(), ",", rand_ctl(), ", ", rand_ctl(), ":"};
    repeat ($urandom_range(8, 2)) begin
      case ($urandom_range(19))
        0: s = {s, rand_ctl()};
        1: s = {s, string'(byte'($urandom_range(255)))};
        2: s = {s, ""};
        default: s = {s, rand_note()};
      endcase
      s = {s, $urandom_range(3) ? "," : " ,"};
    end
    if ($urandom_range(1)) s = {s, rand_note()};
    send_text(s, 1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed songs
    send_text("Song:d=4,o=5,b=100:8a,c#6.,p,h,32g#4..., 1e9,a#,4.b", 1);
    send_text("x:d=0,o=12,b=65535:c,d=255,p,b=0,a,b=1,1c0,255c9#", 1);
    send_text("n:q=3,dd=4,x:1.,3,=5,o=7,do=2,c,8,:cb,", 1);
    send_text("nm:\t b = 40 ,d= :a,99999f,.,C-1,...d", 1);
    send_text("abc", 1);
    send_text(":", 1);
    send_char(8'h00, 1);
    send_char(8'hFF, 1);
    // random songs; long calm stretch in the middle
    while (sent < 600) begin
      idle_pct = (sent > 300 && sent < 420) ? 0 : 16;
      random_song();
    end
    s_tvalid <= 0;
    idle_pct = 16;
    while (pending_notes != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("ringtone_text_note_parser verification clean");
    else $display("ringtone_text_note_parser verification failed");
    $finish;
  end

endmodule
